// ----- rtl/direct_mapped_cache_tag_check_core_defines.svh -----
// Assertion macros for the direct-mapped cache tag check core
`ifndef DIRECT_MAPPED_CACHE_TAG_CHECK_CORE_DEFINES_SVH
`define DIRECT_MAPPED_CACHE_TAG_CHECK_CORE_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define DMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is asserted
`define DMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dmc_pkg.sv -----
// Shared types and constants for the direct-mapped cache tag check
package dmc_pkg;

  localparam int MAX_LINES = 16384;
  localparam int LINE_W    = $clog2(MAX_LINES);
  localparam int ADDR_W    = 32;
  localparam int TAG_W     = 32;
  localparam int CNT_W     = 32;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_FIELD_W = 14;

  localparam logic [CFG_W-1:0] OFFSET_BITS_RESET = 4'd6;
  localparam logic [CFG_W-1:0] INDEX_BITS_RESET  = 4'd4;
  localparam logic [CFG_W-1:0] OFFSET_BITS_LIMIT = 4'd12;
  localparam logic [CFG_W-1:0] INDEX_BITS_LIMIT  = 4'd14;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;

  typedef struct packed {
    logic [LINE_W-1:0] idx;
    logic [TAG_W-1:0]  tag;
  } split_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } entry_t;

endpackage

// ----- rtl/dmc_addr_split.sv -----
// Address split into line index and tag under the configured field widths
module dmc_addr_split (
  input  logic [dmc_pkg::ADDR_W-1:0] address,
  input  logic [dmc_pkg::CFG_W-1:0]  offset_bits,
  input  logic [dmc_pkg::CFG_W-1:0]  index_bits,
  output dmc_pkg::split_t            split
);

  logic [dmc_pkg::CFG_W-1:0]       ob;
  logic [dmc_pkg::CFG_W-1:0]       ib;
  logic [dmc_pkg::CFG_W:0]         tag_shift;
  logic [dmc_pkg::ADDR_W-1:0]      idx_full;
  logic [dmc_pkg::IDX_FIELD_W-1:0] idx_mask;
  logic [dmc_pkg::IDX_FIELD_W-1:0] idx_field;

  always_comb begin
    ob = (offset_bits > dmc_pkg::OFFSET_BITS_LIMIT) ? dmc_pkg::OFFSET_BITS_LIMIT : offset_bits;
    ib = (index_bits > dmc_pkg::INDEX_BITS_LIMIT) ? dmc_pkg::INDEX_BITS_LIMIT : index_bits;
    tag_shift = {1'b0, ob} + {1'b0, ib};
    idx_full  = address >> ob;
    idx_mask  = ~({dmc_pkg::IDX_FIELD_W{1'b1}} << ib);
    idx_field = idx_full[dmc_pkg::IDX_FIELD_W-1:0] & idx_mask;
    split.idx = idx_field[dmc_pkg::LINE_W-1:0];
    split.tag = dmc_pkg::TAG_W'(address >> tag_shift);
  end

endmodule

// ----- rtl/direct_mapped_cache_tag_check_core.sv -----
// Direct-mapped cache tag check: tag store lookup, miss refill and hit/miss counters
// Path: lookup stage register, then output register. Throughput: one request per
// cycle while in_stall is low; the tag store is read at accept and written back as
// the lookup stage advances, with the last refill forwarded to a following request.
// Reset: synchronous; a clearing pass then zeroes all 16384 tag entries, one per
// cycle, with in_stall high throughout the pass. Counters and config reset at once.
`include "direct_mapped_cache_tag_check_core_defines.svh"

module direct_mapped_cache_tag_check_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dmc_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dmc_pkg::ADDR_W-1:0]    in_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic [dmc_pkg::IDX_FIELD_W-1:0] out_line_index,
  output logic [dmc_pkg::CNT_W-1:0]     out_hit_count,
  output logic [dmc_pkg::CNT_W-1:0]     out_miss_count
);

  logic [dmc_pkg::CFG_W-1:0] offset_bits_r;
  logic [dmc_pkg::CFG_W-1:0] index_bits_r;

  dmc_pkg::entry_t mem [dmc_pkg::MAX_LINES];
  dmc_pkg::entry_t rd_r;

  logic                       clr_active_r;
  logic [dmc_pkg::LINE_W-1:0] clr_addr_r;

  dmc_pkg::split_t in_split;
  logic            in_accept;

  logic                       s1_valid_r;
  logic [dmc_pkg::LINE_W-1:0] s1_idx_r;
  logic [dmc_pkg::TAG_W-1:0]  s1_tag_r;
  logic                       s1_go;
  logic                       s1_hit;
  dmc_pkg::entry_t            s1_entry;

  logic                       fwd_valid_r;
  logic [dmc_pkg::LINE_W-1:0] fwd_idx_r;
  logic [dmc_pkg::TAG_W-1:0]  fwd_tag_r;

  logic [dmc_pkg::CNT_W-1:0] hits_total_r;
  logic [dmc_pkg::CNT_W-1:0] misses_total_r;
  logic [dmc_pkg::CNT_W-1:0] hits_total_nxt;
  logic [dmc_pkg::CNT_W-1:0] misses_total_nxt;

  logic                       mem_we;
  logic [dmc_pkg::LINE_W-1:0] mem_waddr;
  dmc_pkg::entry_t            mem_wdata;

  logic                           out_valid_r;
  logic                           out_hit_r;
  logic [dmc_pkg::IDX_FIELD_W-1:0] out_line_index_r;
  logic [dmc_pkg::CNT_W-1:0]      out_hit_count_r;
  logic [dmc_pkg::CNT_W-1:0]      out_miss_count_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= dmc_pkg::OFFSET_BITS_RESET;
      index_bits_r  <= dmc_pkg::INDEX_BITS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dmc_pkg::REG_OFFSET_BITS: offset_bits_r <= cfg_wdata;
        dmc_pkg::REG_INDEX_BITS:  index_bits_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dmc_addr_split u_split (
    .address     (in_address),
    .offset_bits (offset_bits_r),
    .index_bits  (index_bits_r),
    .split       (in_split)
  );

  assign s1_go     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = clr_active_r || (s1_valid_r && !s1_go);
  assign in_accept = in_valid && !in_stall;

  // forward the latest refill over the registered read
  always_comb begin
    if (fwd_valid_r && (fwd_idx_r == s1_idx_r)) begin
      s1_entry.valid = 1'b1;
      s1_entry.tag   = fwd_tag_r;
    end else begin
      s1_entry = rd_r;
    end
    s1_hit = s1_entry.valid && (s1_entry.tag == s1_tag_r);
    hits_total_nxt   = hits_total_r + dmc_pkg::CNT_W'(s1_hit);
    misses_total_nxt = misses_total_r + dmc_pkg::CNT_W'(!s1_hit);
  end

  always_comb begin
    if (clr_active_r) begin
      mem_we          = 1'b1;
      mem_waddr       = clr_addr_r;
      mem_wdata.valid = 1'b0;
      mem_wdata.tag   = '0;
    end else begin
      mem_we          = s1_go && !s1_hit;
      mem_waddr       = s1_idx_r;
      mem_wdata.valid = 1'b1;
      mem_wdata.tag   = s1_tag_r;
    end
  end

  // tag store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      rd_r <= mem[in_split.idx];
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == dmc_pkg::LINE_W'(dmc_pkg::MAX_LINES - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // lookup stage, refill record, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      fwd_valid_r    <= 1'b0;
      hits_total_r   <= '0;
      misses_total_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        hits_total_r   <= hits_total_nxt;
        misses_total_r <= misses_total_nxt;
        out_valid_r    <= 1'b1;
        if (!s1_hit) begin
          fwd_valid_r <= 1'b1;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_idx_r <= in_split.idx;
      s1_tag_r <= in_split.tag;
    end
    if (s1_go && !s1_hit) begin
      fwd_idx_r <= s1_idx_r;
      fwd_tag_r <= s1_tag_r;
    end
    if (s1_go) begin
      out_hit_r        <= s1_hit;
      out_line_index_r <= dmc_pkg::IDX_FIELD_W'(s1_idx_r);
      out_hit_count_r  <= hits_total_nxt;
      out_miss_count_r <= misses_total_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_line_index = out_line_index_r;
  assign out_hit_count  = out_hit_count_r;
  assign out_miss_count = out_miss_count_r;

  `DMC_ASSERT_NOW(a_clear_idle, clk, rst_n, clr_active_r, !s1_valid_r && !out_valid_r,
    "request in flight during clearing pass")
  `DMC_ASSERT_NEXT(a_refill_fwd, clk, rst_n, s1_go && !s1_hit,
    fwd_valid_r && (fwd_idx_r == $past(s1_idx_r)), "refill not recorded for forwarding")
  `DMC_ASSERT_NEXT(a_count_step, clk, rst_n, 1'b1,
    dmc_pkg::CNT_W'(hits_total_r + misses_total_r
      - $past(hits_total_r + misses_total_r)) <= dmc_pkg::CNT_W'(1),
    "counters advanced by more than one request")

endmodule
